/* design/aml_s5_sleep_type_scanner_macros.svh */
// ----------------------------------------------------------------------------
// s5 scanner assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef AML_S5_SLEEP_TYPE_SCANNER_MACROS_SVH
`define AML_S5_SLEEP_TYPE_SCANNER_MACROS_SVH

// same-cycle implication
`define S5_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define S5_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/s5scan_pkg.sv */
// ----------------------------------------------------------------------------
// s5scan_pkg
// shared types and constants of the s5 sleep type scanner
// ----------------------------------------------------------------------------
`default_nettype none

package s5scan_pkg;

    localparam int MAX_CANDIDATES_DEF = 3;
    localparam int RANK_W  = 2;   // age rank, covers up to four cells
    localparam int LIVE_W  = 3;   // live cell count, up to four
    localparam int COUNT_W = 4;   // saturating byte counter

    localparam logic [7:0] NAME_OP      = 8'h08;
    localparam logic [7:0] CH_US        = 8'h5F;
    localparam logic [7:0] CH_S         = 8'h53;
    localparam logic [7:0] CH_5         = 8'h35;
    localparam logic [7:0] PACKAGE_OP   = 8'h12;
    localparam logic [7:0] ZERO_OP      = 8'h00;
    localparam logic [7:0] ONE_OP       = 8'h01;
    localparam logic [7:0] BYTE_PREFIX  = 8'h0A;
    localparam logic [7:0] MAX_ELEMS    = 8'd8;
    localparam logic [7:0] DEFAULT_TYPE = 8'd5;
    localparam logic [COUNT_W-1:0] MIN_TABLE_LEN = 4'd12;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_NAME_US1 = 4'd1,
        ST_NAME_S   = 4'd2,
        ST_NAME_5   = 4'd3,
        ST_NAME_US2 = 4'd4,
        ST_PKG_OP   = 4'd5,
        ST_PKG_LEN  = 4'd6,
        ST_PKG_SKIP = 4'd7,
        ST_NUM_ELEM = 4'd8,
        ST_ELEM_A   = 4'd9,
        ST_VAL_A    = 4'd10,
        ST_ELEM_B   = 4'd11,
        ST_VAL_B    = 4'd12,
        ST_DONE     = 4'd13
    } stage_t;

    // passed from cell to cell: allocation token and oldest-candidate pick
    typedef struct packed {
        logic       alloc;
        logic       seen;
        stage_t     stage;
        logic [7:0] type_a;
        logic [7:0] type_b;
    } cell_link_t;

    // per-cell status seen by the row
    typedef struct packed {
        logic              live;
        logic              fail;
        logic              survived;
        logic [RANK_W-1:0] rank;
    } cell_stat_t;

endpackage

`default_nettype wire

/* design/s5scan_byte_if.sv */
// ----------------------------------------------------------------------------
// s5scan_byte_if
// input channel: one table byte per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface s5scan_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] table_byte;
    logic       is_last;

    modport source (output valid, output table_byte, output is_last, input ready);
    modport sink   (input valid, input table_byte, input is_last, output ready);
endinterface

`default_nettype wire

/* design/s5scan_result_if.sv */
// ----------------------------------------------------------------------------
// s5scan_result_if
// output channel: one scan result per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface s5scan_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] sleep_type_a;
    logic [7:0] sleep_type_b;

    modport source (output valid, output found, output sleep_type_a,
                    output sleep_type_b, input ready);
    modport sink   (input valid, input found, input sleep_type_a,
                    input sleep_type_b, output ready);
endinterface

`default_nettype wire

/* design/s5scan_cell.sv */
// ----------------------------------------------------------------------------
// s5scan_cell
// one candidate tracker: parses a single s5 package candidate
// ----------------------------------------------------------------------------
`default_nettype none

module s5scan_cell #(
    parameter int N = s5scan_pkg::MAX_CANDIDATES_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   clr,
    input  wire logic [7:0]                             table_byte,
    input  wire logic [N-1:0]                           fail_vec,
    input  wire logic [N-1:0][s5scan_pkg::RANK_W-1:0]   rank_vec,
    input  wire logic [s5scan_pkg::RANK_W-1:0]          start_rank,
    input  wire s5scan_pkg::cell_link_t                 chain_in,
    output s5scan_pkg::cell_link_t                      chain_out,
    output s5scan_pkg::cell_stat_t                      stat
);

    s5scan_pkg::stage_t              stage_reg, stage_next, stage_adv;
    logic [1:0]                      skip_reg, skip_next, skip_adv;
    logic [7:0]                      ta_reg, ta_next, ta_adv;
    logic [7:0]                      tb_reg, tb_next, tb_adv;
    logic [s5scan_pkg::RANK_W-1:0]   rank_reg, rank_next;
    logic [s5scan_pkg::LIVE_W-1:0]   drop_older;
    logic                            live, fail, survived, take;

    assign live = (stage_reg != s5scan_pkg::ST_IDLE);

    // advance by one byte
    always_comb
    begin
        stage_adv = stage_reg;
        skip_adv  = skip_reg;
        ta_adv    = ta_reg;
        tb_adv    = tb_reg;
        fail      = 1'b0;
        unique case (stage_reg)
            s5scan_pkg::ST_NAME_US1:
            begin
                fail      = (table_byte != s5scan_pkg::CH_US);
                stage_adv = s5scan_pkg::ST_NAME_S;
            end
            s5scan_pkg::ST_NAME_S:
            begin
                fail      = (table_byte != s5scan_pkg::CH_S);
                stage_adv = s5scan_pkg::ST_NAME_5;
            end
            s5scan_pkg::ST_NAME_5:
            begin
                fail      = (table_byte != s5scan_pkg::CH_5);
                stage_adv = s5scan_pkg::ST_NAME_US2;
            end
            s5scan_pkg::ST_NAME_US2:
            begin
                fail      = (table_byte != s5scan_pkg::CH_US);
                stage_adv = s5scan_pkg::ST_PKG_OP;
            end
            s5scan_pkg::ST_PKG_OP:
            begin
                fail      = (table_byte != s5scan_pkg::PACKAGE_OP);
                stage_adv = s5scan_pkg::ST_PKG_LEN;
            end
            s5scan_pkg::ST_PKG_LEN:
            begin
                // top two bits count extra length bytes
                skip_adv  = table_byte[7:6];
                stage_adv = (table_byte[7:6] != 2'd0) ? s5scan_pkg::ST_PKG_SKIP
                                                      : s5scan_pkg::ST_NUM_ELEM;
            end
            s5scan_pkg::ST_PKG_SKIP:
            begin
                skip_adv = skip_reg - 2'd1;
                if (skip_adv == 2'd0)
                begin
                    stage_adv = s5scan_pkg::ST_NUM_ELEM;
                end
            end
            s5scan_pkg::ST_NUM_ELEM:
            begin
                fail      = (table_byte == 8'd0) || (table_byte > s5scan_pkg::MAX_ELEMS);
                stage_adv = s5scan_pkg::ST_ELEM_A;
            end
            s5scan_pkg::ST_ELEM_A:
            begin
                if ((table_byte == s5scan_pkg::ZERO_OP) || (table_byte == s5scan_pkg::ONE_OP))
                begin
                    ta_adv    = table_byte;
                    stage_adv = s5scan_pkg::ST_ELEM_B;
                end
                else if (table_byte == s5scan_pkg::BYTE_PREFIX)
                begin
                    stage_adv = s5scan_pkg::ST_VAL_A;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            s5scan_pkg::ST_VAL_A:
            begin
                ta_adv    = table_byte;
                stage_adv = s5scan_pkg::ST_ELEM_B;
            end
            s5scan_pkg::ST_ELEM_B:
            begin
                // a bad second element copies the first
                if ((table_byte == s5scan_pkg::ZERO_OP) || (table_byte == s5scan_pkg::ONE_OP))
                begin
                    tb_adv    = table_byte;
                    stage_adv = s5scan_pkg::ST_DONE;
                end
                else if (table_byte == s5scan_pkg::BYTE_PREFIX)
                begin
                    stage_adv = s5scan_pkg::ST_VAL_B;
                end
                else
                begin
                    tb_adv    = ta_reg;
                    stage_adv = s5scan_pkg::ST_DONE;
                end
            end
            s5scan_pkg::ST_VAL_B:
            begin
                tb_adv    = table_byte;
                stage_adv = s5scan_pkg::ST_DONE;
            end
            default:
            begin
                stage_adv = stage_reg;
            end
        endcase
    end

    // rank falls by the number of older cells failing on this byte
    always_comb
    begin
        drop_older = '0;
        for (int j = 0; j < N; j++)
        begin
            if (fail_vec[j] && (rank_vec[j] < rank_reg))
            begin
                drop_older = drop_older + s5scan_pkg::LIVE_W'(1);
            end
        end
    end

    assign survived = live && !fail;
    assign take     = chain_in.alloc && !survived;

    always_comb
    begin
        chain_out       = chain_in;
        chain_out.alloc = chain_in.alloc && survived;
        if (take)
        begin
            stage_next = s5scan_pkg::ST_NAME_US1;
            skip_next  = 2'd0;
            ta_next    = 8'd0;
            tb_next    = 8'd0;
            rank_next  = start_rank;
        end
        else if (survived)
        begin
            stage_next = stage_adv;
            skip_next  = skip_adv;
            ta_next    = ta_adv;
            tb_next    = tb_adv;
            rank_next  = rank_reg - drop_older[s5scan_pkg::RANK_W-1:0];
        end
        else
        begin
            stage_next = s5scan_pkg::ST_IDLE;
            skip_next  = skip_reg;
            ta_next    = ta_reg;
            tb_next    = tb_reg;
            rank_next  = '0;
        end
        // oldest pick on the updated state, lowest index first
        if (!chain_in.seen && (stage_next != s5scan_pkg::ST_IDLE) && (rank_next == '0))
        begin
            chain_out.seen   = 1'b1;
            chain_out.stage  = stage_next;
            chain_out.type_a = ta_next;
            chain_out.type_b = tb_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= s5scan_pkg::ST_IDLE;
            rank_reg  <= '0;
        end
        else if (clr)
        begin
            stage_reg <= s5scan_pkg::ST_IDLE;
            rank_reg  <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            skip_reg <= skip_next;
            ta_reg   <= ta_next;
            tb_reg   <= tb_next;
        end
    end

    assign stat.live     = live;
    assign stat.fail     = live && fail;
    assign stat.survived = survived;
    assign stat.rank     = rank_reg;

endmodule

`default_nettype wire

/* design/aml_s5_sleep_type_scanner.sv */
// ----------------------------------------------------------------------------
// aml_s5_sleep_type_scanner
// scans an aml table byte stream for the s5 package and reports sleep types
// ----------------------------------------------------------------------------
// usage
//   bytes  : one table byte per transaction, is_last marks the final byte
//   result : exactly one transaction per table: found plus both sleep types
//            (5 and 5 when the package is not found)
//   one byte is taken every cycle while bytes.ready is high; each byte passes
//   through the row of candidate cells combinationally, so the rate is set
//   by that cell update; the result is registered, valid in the cycle after
//   its deciding byte; a result may come before the table ends; later bytes
//   are swallowed until is_last, which clears the block ready for the next table
//   the output register holds a result while the receiver stalls; bytes are
//   not taken then, as ready needs the register empty or being drained
//   reset: all cells idle, counters cleared, no result pending
// ----------------------------------------------------------------------------
`default_nettype none

module aml_s5_sleep_type_scanner #(
    parameter int MAX_CANDIDATES = s5scan_pkg::MAX_CANDIDATES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    s5scan_byte_if.sink       bytes,
    s5scan_result_if.source   result
);

`include "aml_s5_sleep_type_scanner_macros.svh"

    localparam int N = MAX_CANDIDATES;

    // row of candidate cells
    s5scan_pkg::cell_link_t                   chain [0:N];
    s5scan_pkg::cell_stat_t                   stat  [N];
    logic [N-1:0]                             fail_vec;
    logic [N-1:0]                             surv_vec;
    logic [N-1:0]                             live_vec;
    logic [N-1:0]                             oldest_vec;
    logic [N-1:0][s5scan_pkg::RANK_W-1:0]     rank_vec;
    logic [s5scan_pkg::LIVE_W-1:0]            live_after;
    logic                                     start;

    // control
    logic                                     acc, en, clr, emit, enough;
    logic                                     finished_reg, finished_next;
    logic [s5scan_pkg::COUNT_W-1:0]           count_reg, count_next, count_inc;

    // result staging
    logic                                     out_valid_reg, out_valid_next;
    logic                                     found_reg, found_next;
    logic [7:0]                               ta_reg, ta_next;
    logic [7:0]                               tb_reg, tb_next;
    logic                                     found_v;
    logic [7:0]                               ta_v, tb_v;

    assign bytes.ready = !out_valid_reg || result.ready;
    assign acc         = bytes.valid && bytes.ready;
    assign en          = acc && !finished_reg;
    // the last byte always ends the table, whatever came before
    assign clr         = acc && bytes.is_last;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            fail_vec[k]   = stat[k].fail;
            surv_vec[k]   = stat[k].survived;
            live_vec[k]   = stat[k].live;
            rank_vec[k]   = stat[k].rank;
            oldest_vec[k] = stat[k].live && (stat[k].rank == '0);
        end
    end

    // a new 0x08 takes the lowest free cell if one is left after failures
    assign live_after = s5scan_pkg::LIVE_W'($countones(surv_vec));
    assign start      = (bytes.table_byte == s5scan_pkg::NAME_OP) &&
                        (live_after < s5scan_pkg::LIVE_W'(N));

    always_comb
    begin
        chain[0]       = '0;
        chain[0].alloc = start;
        chain[0].stage = s5scan_pkg::ST_IDLE;
    end

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        s5scan_cell #(
            .N (N)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .clr        (clr),
            .table_byte (bytes.table_byte),
            .fail_vec   (fail_vec),
            .rank_vec   (rank_vec),
            .start_rank (live_after[s5scan_pkg::RANK_W-1:0]),
            .chain_in   (chain[k]),
            .chain_out  (chain[k+1]),
            .stat       (stat[k])
        );
    end

    // saturating byte count, tables shorter than the minimum never match
    assign count_inc = (count_reg < s5scan_pkg::MIN_TABLE_LEN) ?
                       count_reg + s5scan_pkg::COUNT_W'(1) : count_reg;
    assign enough    = (count_inc >= s5scan_pkg::MIN_TABLE_LEN);

    // decide on the oldest candidate after this byte
    always_comb
    begin
        found_v = 1'b0;
        ta_v    = s5scan_pkg::DEFAULT_TYPE;
        tb_v    = s5scan_pkg::DEFAULT_TYPE;
        if (chain[N].seen && enough)
        begin
            if (chain[N].stage == s5scan_pkg::ST_DONE)
            begin
                found_v = 1'b1;
                ta_v    = chain[N].type_a;
                tb_v    = chain[N].type_b;
            end
            else if (bytes.is_last && ((chain[N].stage == s5scan_pkg::ST_ELEM_B) ||
                                       (chain[N].stage == s5scan_pkg::ST_VAL_B)))
            begin
                // table cut inside the second element
                found_v = 1'b1;
                ta_v    = chain[N].type_a;
                tb_v    = chain[N].type_a;
            end
        end
    end

    assign emit = en && (bytes.is_last ||
                         (chain[N].seen && enough &&
                          (chain[N].stage == s5scan_pkg::ST_DONE)));

    always_comb
    begin
        finished_next  = finished_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        if (clr)
        begin
            finished_next = 1'b0;
            count_next    = '0;
        end
        else if (en)
        begin
            finished_next = emit;
            count_next    = count_inc;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            found_next     = found_v;
            ta_next        = ta_v;
            tb_next        = tb_v;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finished_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            finished_reg  <= finished_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = found_reg;
    assign result.sleep_type_a = ta_reg;
    assign result.sleep_type_b = tb_reg;

    // a not-found result always carries the default sleep types
    `S5_ASSERT_NOW(a_not_found_default, out_valid_reg && !found_reg, (ta_reg == s5scan_pkg::DEFAULT_TYPE) && (tb_reg == s5scan_pkg::DEFAULT_TYPE), "not-found result without default types")
    // age ranks of live cells stay distinct, so at most one oldest
    `S5_ASSERT_NOW(a_single_oldest, 1'b1, $onehot0(oldest_vec), "more than one oldest candidate")
    // the last byte of a table leaves the block cleared
    `S5_ASSERT_NXT(a_last_clears, acc && bytes.is_last, (live_vec == '0) && !finished_reg, "block not cleared after last byte")
    // bytes after a result do not touch the cells
    `S5_ASSERT_NXT(a_ignored_bytes, finished_reg && acc && !bytes.is_last, $stable(live_vec) && finished_reg, "cells changed after a result")

endmodule

`default_nettype wire
